@@ rtl/core/chunk_deframe_check_top_macros.svh @@
// Assertion helpers used by the deframer engine (cdfc_engine).
// Both expect clk and rst in the scope where they are used.
`ifndef CHUNK_DEFRAME_CHECK_TOP_MACROS_SVH
`define CHUNK_DEFRAME_CHECK_TOP_MACROS_SVH

// Same-cycle implication.
`define CDFC_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDFC_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cdfc_pkg.sv @@
package cdfc_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int LEN_BYTES   = 4;
  localparam int CHECK_INDEX = 11;

  localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SMALL  = 3'd1,
    ST_LARGE  = 3'd2,
    ST_SEQ    = 3'd3,
    ST_PARITY = 3'd4
  } status_t;

  typedef struct packed {
    logic       command;
    logic [7:0] stream_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_end;
    logic [2:0] status;
  } result_t;

endpackage

@@ rtl/core/chunk_deframe_check_top.sv @@
// Channel   Handshake                    Payload
// item      item_valid / item_ready      item   (cdfc_pkg::item_t)
// result    result_valid / result_ready  result (cdfc_pkg::result_t)
// config    cfg_wr_en                    cfg_wr_data (max_chunk_len)
//
// One byte a cycle sustained while the output register is free or being read;
// a byte passes from the input register through the check logic into the
// output register. The 64-bit sequence compare and add at the twelfth header
// byte set the longest path. Synchronous reset clears control state and loads
// max_chunk_len with 8192. A held result stalls the input register, and bytes
// without a result wait their turn behind it.
module chunk_deframe_check_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  cdfc_pkg::item_t  item,
  output logic             result_valid,
  input  logic             result_ready,
  output cdfc_pkg::result_t result
);

  logic              held_valid;
  cdfc_pkg::item_t   held;
  logic              space;
  logic              move;
  logic              res_valid;
  cdfc_pkg::result_t res;

  // advance the held transaction when the output side can take its result
  assign move = held_valid && space;

  cdfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .move       (move),
    .held_valid (held_valid),
    .held       (held)
  );

  cdfc_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (move),
    .item        (held),
    .res_valid   (res_valid),
    .res         (res)
  );

  cdfc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (move && res_valid),
    .res          (res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ rtl/core/cdfc_in_reg.sv @@
module cdfc_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  cdfc_pkg::item_t item,
  input  logic           move,
  output logic           held_valid,
  output cdfc_pkg::item_t held
);

  assign item_ready = !held_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held <= item;
    end
  end

endmodule

@@ rtl/core/cdfc_engine.sv @@
`include "chunk_deframe_check_top_macros.svh"

module cdfc_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             go,
  input  cdfc_pkg::item_t  item,
  output logic             res_valid,
  output cdfc_pkg::result_t res
);

  localparam logic [16:0] PAD_MASK = 17'(cdfc_pkg::BLOCK_BYTES - 1);

  logic [15:0] max_chunk_len;
  logic [15:0] byte_index, byte_index_next;
  logic [31:0] header_length, header_length_next;
  logic [63:0] header_sequence, header_sequence_next;
  logic [63:0] expected_sequence, expected_sequence_next;
  logic [31:0] parity_lanes, parity_lanes_next;
  logic        halted, halted_next;

  logic [7:0]  b;
  logic        in_header;
  logic        in_payload;
  logic [31:0] lane_bits;
  logic [16:0] padded;
  logic        last_byte;
  cdfc_pkg::status_t check_st;

  assign b = item.stream_byte;
  assign in_header  = byte_index < 16'(cdfc_pkg::BLOCK_BYTES);
  assign in_payload = !in_header && ({16'b0, byte_index} < header_length);
  // past the check the length is known to fit 16 bits
  assign padded    = ({1'b0, header_length[15:0]} + PAD_MASK) & ~PAD_MASK;
  assign last_byte = (byte_index > 16'(cdfc_pkg::CHECK_INDEX)) &&
                     (({1'b0, byte_index} + 17'd1) >= padded);

  always_comb begin
    case (byte_index[1:0])
      2'd0:    lane_bits = {24'b0, b};
      2'd1:    lane_bits = {16'b0, b, 8'b0};
      2'd2:    lane_bits = {8'b0, b, 16'b0};
      default: lane_bits = {b, 24'b0};
    endcase
  end

  always_comb begin
    if (header_length <= 32'(cdfc_pkg::BLOCK_BYTES)) begin
      check_st = cdfc_pkg::ST_SMALL;
    end else if (header_length > {16'b0, max_chunk_len}) begin
      check_st = cdfc_pkg::ST_LARGE;
    end else if (header_sequence_next != expected_sequence) begin
      check_st = cdfc_pkg::ST_SEQ;
    end else begin
      check_st = cdfc_pkg::ST_OK;
    end
  end

  always_comb begin
    header_length_next = header_length;
    header_sequence_next = header_sequence;
    if (byte_index < 16'(cdfc_pkg::LEN_BYTES)) begin
      header_length_next = {header_length[23:0], b};
    end else if (byte_index <= 16'(cdfc_pkg::CHECK_INDEX)) begin
      header_sequence_next = {header_sequence[55:0], b};
    end
  end

  always_comb begin
    byte_index_next        = byte_index;
    expected_sequence_next = expected_sequence;
    parity_lanes_next      = parity_lanes;
    halted_next            = halted;
    res_valid              = 1'b0;
    res                    = '0;
    if (item.command == cdfc_pkg::CMD_RESTART) begin
      byte_index_next        = '0;
      expected_sequence_next = '0;
      parity_lanes_next      = '0;
      halted_next            = 1'b0;
    end else if (!halted) begin
      if (byte_index == 16'(cdfc_pkg::CHECK_INDEX) && check_st != cdfc_pkg::ST_OK) begin
        // header rejected: report and stop
        halted_next = 1'b1;
        res_valid   = 1'b1;
        res.chunk_end = 1'b1;
        res.status    = check_st;
      end else begin
        if (byte_index == 16'(cdfc_pkg::CHECK_INDEX)) begin
          expected_sequence_next = expected_sequence + {32'b0, header_length};
        end
        if (in_header || in_payload) begin
          parity_lanes_next = parity_lanes ^ lane_bits;
        end
        res.payload_byte  = in_payload ? b : 8'd0;
        res.payload_valid = in_payload;
        if (last_byte) begin
          byte_index_next   = '0;
          parity_lanes_next = '0;
          halted_next       = (parity_lanes ^ (in_payload ? lane_bits : 32'b0)) != 32'b0;
          res_valid         = 1'b1;
          res.chunk_end     = 1'b1;
          res.status        = halted_next ? cdfc_pkg::ST_PARITY : cdfc_pkg::ST_OK;
        end else begin
          byte_index_next = byte_index + 16'd1;
          res_valid       = in_payload;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk_len <= cdfc_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_chunk_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index        <= '0;
      header_length     <= '0;
      header_sequence   <= '0;
      expected_sequence <= '0;
      parity_lanes      <= '0;
      halted            <= 1'b0;
    end else if (go) begin
      byte_index        <= byte_index_next;
      expected_sequence <= expected_sequence_next;
      parity_lanes      <= parity_lanes_next;
      halted            <= halted_next;
      // clear the header on restart or on a chunk's last byte
      if (item.command == cdfc_pkg::CMD_RESTART || (!halted && last_byte)) begin
        header_length   <= '0;
        header_sequence <= '0;
      end else if (!halted) begin
        header_length   <= header_length_next;
        header_sequence <= header_sequence_next;
      end
    end
  end

  `CDFC_ASSERT_NOW(a_plain_result_is_payload, go && res_valid && !res.chunk_end, res.payload_valid && res.status == cdfc_pkg::ST_OK, "result without chunk end must carry payload")
  `CDFC_ASSERT_NEXT(a_error_halts, go && res_valid && res.chunk_end && res.status != cdfc_pkg::ST_OK, halted, "error verdict did not halt")
  `CDFC_ASSERT_NOW(a_halted_silent, go && halted && item.command == cdfc_pkg::CMD_BYTE, !res_valid, "halted block produced a result")
  `CDFC_ASSERT_NOW(a_index_in_chunk, !halted && byte_index > 16'(cdfc_pkg::CHECK_INDEX), {1'b0, byte_index} < padded, "byte index ran past padded chunk")

endmodule

@@ rtl/core/cdfc_out_reg.sv @@
module cdfc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  cdfc_pkg::result_t res,
  output logic             space,
  output logic             result_valid,
  input  logic             result_ready,
  output cdfc_pkg::result_t result
);

  assign space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (space) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && res_valid) begin
      result <= res;
    end
  end

endmodule
